// ===== sv/rfm_pkg.sv =====
package rfm_pkg;

    localparam int CAPTURE_BITS = 16;
    localparam int FREQ_W       = 16;
    localparam int BP_W         = 14;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 16;

    // floor(N / (992 * c)) == floor(floor(N / 992) / c)
    localparam longint FREQ_NUMERATOR = 64'd1048576000;
    localparam longint COUNT_SCALE    = 64'd992;
    localparam longint DIVIDEND       = FREQ_NUMERATOR / COUNT_SCALE;
    localparam int     QUOT_W         = $clog2(DIVIDEND + 1);
    localparam int     STEP_W         = $clog2(QUOT_W);
    localparam int     PROD_W         = FREQ_W + BP_W;

    localparam logic [QUOT_W-1:0] DIVIDEND_C = QUOT_W'(DIVIDEND);
    localparam logic [FREQ_W-1:0] FREQ_MAX   = '1;
    localparam logic [BP_W-1:0]   BP_SCALE   = BP_W'(10000);

    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_ONE_LIMIT   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_TWO_LIMIT   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_THREE_LIMIT = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FOUR_LIMIT  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_ONE_BP      = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_TWO_BP      = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_THREE_BP    = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_BAND_FOUR_BP     = 3'd7;

    localparam logic [FREQ_W-1:0] RST_BAND_ONE_LIMIT   = 16'd5000;
    localparam logic [FREQ_W-1:0] RST_BAND_TWO_LIMIT   = 16'd10000;
    localparam logic [FREQ_W-1:0] RST_BAND_THREE_LIMIT = 16'd17000;
    localparam logic [FREQ_W-1:0] RST_BAND_FOUR_LIMIT  = 16'd20000;
    localparam logic [BP_W-1:0]   RST_BAND_ONE_BP      = 14'd46;
    localparam logic [BP_W-1:0]   RST_BAND_TWO_BP      = 14'd90;
    localparam logic [BP_W-1:0]   RST_BAND_THREE_BP    = 14'd230;
    localparam logic [BP_W-1:0]   RST_BAND_FOUR_BP     = 14'd800;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_DIV    = 5'b00010,
        ST_BAND   = 5'b00100,
        ST_MUL    = 5'b01000,
        ST_DECIDE = 5'b10000
    } state_t;

    typedef struct packed {
        logic load;
        logic div_step;
        logic band;
        logic mul;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic zero_pair;
    } dp_status_t;

endpackage

// ===== sv/rfm_ctrl.sv =====
module rfm_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    output logic                m_valid,
    input  logic                m_ready,
    input  rfm_pkg::dp_status_t status,
    output rfm_pkg::dp_cmd_t    cmd
);

    rfm_pkg::state_t                state_reg, state_next;
    logic [rfm_pkg::STEP_W-1:0]     cnt_reg, cnt_next;
    logic                           m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == rfm_pkg::ST_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            rfm_pkg::ST_IDLE: begin
                // a pair of zero stamps is taken and dropped
                if (s_valid && !status.zero_pair) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = rfm_pkg::ST_DIV;
                end
            end
            rfm_pkg::ST_DIV: begin
                cmd.div_step = 1'b1;
                if (cnt_reg == rfm_pkg::STEP_W'(rfm_pkg::QUOT_W - 1)) begin
                    state_next = rfm_pkg::ST_BAND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            rfm_pkg::ST_BAND: begin
                cmd.band   = 1'b1;
                state_next = rfm_pkg::ST_MUL;
            end
            rfm_pkg::ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = rfm_pkg::ST_DECIDE;
            end
            rfm_pkg::ST_DECIDE: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.commit = 1'b1;
                    state_next = rfm_pkg::ST_IDLE;
                end
            end
            default: state_next = rfm_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        priority if (cmd.commit) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rfm_pkg::ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

// ===== sv/rfm_datapath.sv =====
module rfm_datapath (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic [rfm_pkg::CAPTURE_BITS-1:0]    s_first_edge,
    input  logic [rfm_pkg::CAPTURE_BITS-1:0]    s_second_edge,
    input  rfm_pkg::dp_cmd_t                    cmd,
    output rfm_pkg::dp_status_t                 status,
    output logic [rfm_pkg::FREQ_W-1:0]          m_measured_freq,
    output logic                                m_display_update,
    output logic [rfm_pkg::FREQ_W-1:0]          m_shown_freq
);

    localparam int CB = rfm_pkg::CAPTURE_BITS;
    localparam int QW = rfm_pkg::QUOT_W;
    localparam int FW = rfm_pkg::FREQ_W;
    localparam int BW = rfm_pkg::BP_W;
    localparam int PW = rfm_pkg::PROD_W;

    // configuration
    logic [FW-1:0] lim_reg [4];
    logic [BW-1:0] bp_reg  [4];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lim_reg[0] <= rfm_pkg::RST_BAND_ONE_LIMIT;
            lim_reg[1] <= rfm_pkg::RST_BAND_TWO_LIMIT;
            lim_reg[2] <= rfm_pkg::RST_BAND_THREE_LIMIT;
            lim_reg[3] <= rfm_pkg::RST_BAND_FOUR_LIMIT;
            bp_reg[0]  <= rfm_pkg::RST_BAND_ONE_BP;
            bp_reg[1]  <= rfm_pkg::RST_BAND_TWO_BP;
            bp_reg[2]  <= rfm_pkg::RST_BAND_THREE_BP;
            bp_reg[3]  <= rfm_pkg::RST_BAND_FOUR_BP;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rfm_pkg::CFG_BAND_ONE_LIMIT:   lim_reg[0] <= cfg_data;
                rfm_pkg::CFG_BAND_TWO_LIMIT:   lim_reg[1] <= cfg_data;
                rfm_pkg::CFG_BAND_THREE_LIMIT: lim_reg[2] <= cfg_data;
                rfm_pkg::CFG_BAND_FOUR_LIMIT:  lim_reg[3] <= cfg_data;
                rfm_pkg::CFG_BAND_ONE_BP:      bp_reg[0]  <= cfg_data[BW-1:0];
                rfm_pkg::CFG_BAND_TWO_BP:      bp_reg[1]  <= cfg_data[BW-1:0];
                rfm_pkg::CFG_BAND_THREE_BP:    bp_reg[2]  <= cfg_data[BW-1:0];
                rfm_pkg::CFG_BAND_FOUR_BP:     bp_reg[3]  <= cfg_data[BW-1:0];
                default: ;
            endcase
        end
    end

    assign status.zero_pair = (s_first_edge == '0) && (s_second_edge == '0);

    // restoring divider: DIVIDEND / count, one quotient bit per cycle
    logic [CB-1:0] div_reg;
    logic [CB-1:0] rem_reg, rem_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CB:0]   trial;
    logic          fits;

    assign trial = {rem_reg, q_reg[QW-1]};
    assign fits  = (trial >= {1'b0, div_reg});

    always_comb begin
        rem_next = rem_reg;
        q_next   = q_reg;
        if (cmd.load) begin
            rem_next = '0;
            q_next   = rfm_pkg::DIVIDEND_C;
        end else if (cmd.div_step) begin
            rem_next = fits ? CB'(trial - {1'b0, div_reg}) : trial[CB-1:0];
            q_next   = {q_reg[QW-2:0], fits};
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        if (cmd.load) begin
            div_reg <= s_second_edge - s_first_edge;
        end
    end

    // band selection and difference
    logic [FW-1:0] last_reg;
    logic [FW-1:0] f_reg, f_calc;
    logic [FW-1:0] diff_reg, diff_calc;
    logic [BW-1:0] thr_reg, thr_calc;
    logic          in_band_reg, in_band_calc;
    logic          sat;

    assign sat    = (div_reg == '0) || (q_reg[QW-1:FW] != '0);
    assign f_calc = sat ? rfm_pkg::FREQ_MAX : q_reg[FW-1:0];
    assign diff_calc = (f_calc > last_reg) ? (f_calc - last_reg) : (last_reg - f_calc);

    always_comb begin
        in_band_calc = 1'b1;
        priority if (f_calc <= lim_reg[0]) begin
            thr_calc = bp_reg[0];
        end else if (f_calc <= lim_reg[1]) begin
            thr_calc = bp_reg[1];
        end else if (f_calc <= lim_reg[2]) begin
            thr_calc = bp_reg[2];
        end else if (f_calc <= lim_reg[3]) begin
            thr_calc = bp_reg[3];
        end else begin
            thr_calc     = '0;
            in_band_calc = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.band) begin
            f_reg       <= f_calc;
            diff_reg    <= diff_calc;
            thr_reg     <= thr_calc;
            in_band_reg <= in_band_calc;
        end
    end

    // scaled comparison operands
    logic [PW-1:0] lhs_reg, rhs_reg;

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            lhs_reg <= PW'(diff_reg) * PW'(rfm_pkg::BP_SCALE);
            rhs_reg <= PW'(thr_reg) * PW'(last_reg);
        end
    end

    // decision and result register
    logic          upd;
    logic [FW-1:0] last_next;
    logic [FW-1:0] meas_reg, shown_reg;
    logic          upd_reg;

    assign upd       = (last_reg == '0) || (in_band_reg && (lhs_reg > rhs_reg));
    assign last_next = (cmd.commit && upd) ? f_reg : last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_reg <= '0;
        end else begin
            last_reg <= last_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            meas_reg  <= f_reg;
            upd_reg   <= upd;
            shown_reg <= last_next;
        end
    end

    assign m_measured_freq  = meas_reg;
    assign m_display_update = upd_reg;
    assign m_shown_freq     = shown_reg;

endmodule

// ===== sv/reciprocal_freq_meter_with_hysteresis.sv =====
// Reciprocal frequency meter with display hysteresis. Each input transfer
// carries two timer captures; their wrapped difference is the period count
// and the result is floor(2^20 / (0.992 * count)), saturated at 65535 (also
// for a zero count). A pair of zero captures is consumed with no result. The
// shown frequency is replaced when the change exceeds the threshold of the
// band the new value falls in, in basis points of the shown value; above the
// top band it holds. While the shown value is zero, it is always replaced.
// Each item passes the bit-serial restoring divider (one quotient bit per
// cycle), then band select, multiply and decide. A new item is taken as
// soon as the previous one has been placed in the output register, even
// while that result waits. Configuration writes take effect at once and
// belong in idle periods.
module reciprocal_freq_meter_with_hysteresis (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [rfm_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [rfm_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [rfm_pkg::CAPTURE_BITS-1:0]    s_first_edge,
    input  logic [rfm_pkg::CAPTURE_BITS-1:0]    s_second_edge,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [rfm_pkg::FREQ_W-1:0]          m_measured_freq,
    output logic                                m_display_update,
    output logic [rfm_pkg::FREQ_W-1:0]          m_shown_freq
);

    rfm_pkg::dp_cmd_t    cmd;
    rfm_pkg::dp_status_t status;

    rfm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    rfm_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_first_edge     (s_first_edge),
        .s_second_edge    (s_second_edge),
        .cmd              (cmd),
        .status           (status),
        .m_measured_freq  (m_measured_freq),
        .m_display_update (m_display_update),
        .m_shown_freq     (m_shown_freq)
    );

endmodule

// ===== sv/rfm_checker.sv =====
module rfm_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic [rfm_pkg::CAPTURE_BITS-1:0]    s_first_edge,
    input logic [rfm_pkg::CAPTURE_BITS-1:0]    s_second_edge,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic [rfm_pkg::FREQ_W-1:0]          m_measured_freq,
    input logic                                m_display_update,
    input logic [rfm_pkg::FREQ_W-1:0]          m_shown_freq
);

    logic zero_pair;
    assign zero_pair = (s_first_edge == '0) && (s_second_edge == '0);

    // reset leaves no result pending and the input open
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("not idle after reset");

    // a real measurement occupies the block
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !zero_pair |=> !s_ready)
        else $error("input still ready after measurement transfer");

    // a dropped zero pair must not produce a result
    a_zero_pair_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && zero_pair && !m_valid |=> !m_valid)
        else $error("result produced for zero capture pair");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_measured_freq)
            && $stable(m_display_update) && $stable(m_shown_freq))
        else $error("stalled result changed");

endmodule

bind reciprocal_freq_meter_with_hysteresis rfm_checker u_rfm_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_valid          (s_valid),
    .s_ready          (s_ready),
    .s_first_edge     (s_first_edge),
    .s_second_edge    (s_second_edge),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_measured_freq  (m_measured_freq),
    .m_display_update (m_display_update),
    .m_shown_freq     (m_shown_freq)
);

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import rfm_pkg::*;

    localparam longint unsigned METER_NUMERATOR = 64'd1048576000;
    localparam longint unsigned COUNT_WEIGHT    = 64'd992;
    localparam longint unsigned FREQ_CEIL       = 64'd65535;
    localparam longint unsigned BASIS_POINTS    = 64'd10000;
    localparam int              SETTLE_CYCLES   = 40;
    localparam int              ITEMS_PER_PHASE = 180;
    localparam int              NUM_PHASES      = 8;

    typedef struct packed {
        logic [FREQ_W-1:0] measured_freq;
        logic              display_update;
        logic [FREQ_W-1:0] shown_freq;
    } freq_reading_t;

    // first stamp in the upper half, second stamp in the lower half
    localparam logic [31:0] DIRECTED_PAIRS[22] = '{
        32'h0000_0000, 32'h0000_0064, 32'hFFFF_FFFF, 32'h04D2_04D2,
        32'hFFFF_0000, 32'h0000_FFFF, 32'h8000_7FFF, 32'hFFF0_0010,
        32'h5555_AAAA, 32'hAAAA_5555, 32'h0000_0000, 32'h1000_10D4,
        32'h2000_20D3, 32'h3000_306A, 32'h4000_4069, 32'h5000_503F,
        32'h6000_603E, 32'h7000_7035, 32'hF000_F034, 32'hFFE0_0000,
        32'h0001_0012, 32'h0000_0010
    };

    class freq_scoreboard;
        logic [FREQ_W-1:0] band_limit[4];
        logic [BP_W-1:0]   band_bp[4];
        logic [FREQ_W-1:0] last_shown;
        freq_reading_t     expected_readings[$];
        int                errors;

        function new();
            band_limit = '{RST_BAND_ONE_LIMIT, RST_BAND_TWO_LIMIT,
                           RST_BAND_THREE_LIMIT, RST_BAND_FOUR_LIMIT};
            band_bp    = '{RST_BAND_ONE_BP, RST_BAND_TWO_BP,
                           RST_BAND_THREE_BP, RST_BAND_FOUR_BP};
            last_shown = '0;
            errors     = 0;
        endfunction

        function void write_reg(input logic [CFG_INDEX_W-1:0] index,
                                input logic [CFG_DATA_W-1:0] data);
            if (index < CFG_BAND_ONE_BP)
                band_limit[index - CFG_BAND_ONE_LIMIT] = data[FREQ_W-1:0];
            else
                band_bp[index - CFG_BAND_ONE_BP] = data[BP_W-1:0];
        endfunction

        // work out the reading caused by one accepted capture pair
        function void note_pair(input logic [CAPTURE_BITS-1:0] first_edge,
                                input logic [CAPTURE_BITS-1:0] second_edge);
            logic [CAPTURE_BITS-1:0] span;
            longint unsigned         freq;
            longint unsigned         gap;
            longint unsigned         bp;
            bit                      in_band;
            bit                      update;
            freq_reading_t           r;
            if (first_edge == '0 && second_edge == '0)
                return;
            span = second_edge - first_edge;
            if (span == '0) begin
                freq = FREQ_CEIL;
            end else begin
                freq = METER_NUMERATOR / (COUNT_WEIGHT * longint'(span));
                if (freq > FREQ_CEIL)
                    freq = FREQ_CEIL;
            end
            in_band = 1'b1;
            bp = 0;
            if (freq <= band_limit[0])
                bp = band_bp[0];
            else if (freq <= band_limit[1])
                bp = band_bp[1];
            else if (freq <= band_limit[2])
                bp = band_bp[2];
            else if (freq <= band_limit[3])
                bp = band_bp[3];
            else
                in_band = 1'b0;
            if (last_shown == '0) begin
                update = 1'b1;
            end else if (!in_band) begin
                update = 1'b0;
            end else begin
                gap = (freq > last_shown) ? freq - last_shown : last_shown - freq;
                update = (gap * BASIS_POINTS) > (bp * last_shown);
            end
            if (update)
                last_shown = FREQ_W'(freq);
            r.measured_freq  = FREQ_W'(freq);
            r.display_update = update;
            r.shown_freq     = last_shown;
            expected_readings.push_back(r);
        endfunction

        function void check_reading(input freq_reading_t got);
            freq_reading_t want;
            if (expected_readings.size() == 0) begin
                $error("unexpected reading: measured_freq %0d shown_freq %0d",
                       got.measured_freq, got.shown_freq);
                errors++;
                return;
            end
            want = expected_readings.pop_front();
            if (got.measured_freq !== want.measured_freq) begin
                $error("measured_freq: expected %0d, actual %0d",
                       want.measured_freq, got.measured_freq);
                errors++;
            end
            if (got.display_update !== want.display_update) begin
                $error("display_update: expected %0d, actual %0d",
                       want.display_update, got.display_update);
                errors++;
            end
            if (got.shown_freq !== want.shown_freq) begin
                $error("shown_freq: expected %0d, actual %0d",
                       want.shown_freq, got.shown_freq);
                errors++;
            end
        endfunction
    endclass

    logic                    aclk;
    logic                    aresetn          = 1'b0;
    logic                    cfg_wr_en        = 1'b0;
    logic [CFG_INDEX_W-1:0]  cfg_index        = '0;
    logic [CFG_DATA_W-1:0]   cfg_data         = '0;
    logic                    s_valid          = 1'b0;
    logic                    s_ready;
    logic [CAPTURE_BITS-1:0] s_first_edge     = '0;
    logic [CAPTURE_BITS-1:0] s_second_edge    = '0;
    logic                    m_valid;
    logic                    m_ready          = 1'b0;
    logic [FREQ_W-1:0]       m_measured_freq;
    logic                    m_display_update;
    logic [FREQ_W-1:0]       m_shown_freq;

    int unsigned    src_idle_pct   = 0;
    int unsigned    sink_stall_pct = 0;
    int unsigned    track_span     = 211;
    freq_scoreboard sb             = new();

    reciprocal_freq_meter_with_hysteresis dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_first_edge     (s_first_edge),
        .s_second_edge    (s_second_edge),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_measured_freq  (m_measured_freq),
        .m_display_update (m_display_update),
        .m_shown_freq     (m_shown_freq)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                sb.note_pair(s_first_edge, s_second_edge);
            if (m_valid && m_ready)
                sb.check_reading({m_measured_freq, m_display_update, m_shown_freq});
        end
    end

    // valid stays up from one transfer to the next unless the sender idles
    task automatic send_pair(input logic [CAPTURE_BITS-1:0] first_edge,
                             input logic [CAPTURE_BITS-1:0] second_edge);
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_first_edge  <= first_edge;
        s_second_edge <= second_edge;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.expected_readings.size() != 0);
    endtask

    task automatic load_settings(input logic [CFG_DATA_W-1:0] vals[8]);
        for (int i = 0; i < 8; i++) begin
            cfg_wr_en <= 1'b1;
            cfg_index <= CFG_INDEX_W'(i);
            cfg_data  <= vals[i];
            @(posedge aclk);
            sb.write_reg(CFG_INDEX_W'(i), vals[i]);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // mostly slowly drifting periods so readings hover around the shown value
    task automatic send_random_pairs(input int count);
        logic [CAPTURE_BITS-1:0] a;
        logic [CAPTURE_BITS-1:0] b;
        int unsigned             roll;
        int unsigned             step;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(99);
            a = CAPTURE_BITS'($urandom);
            if (roll < 6) begin
                a = '0;
                b = '0;
            end else if (roll < 10) begin
                b = a;
            end else if (roll < 25) begin
                b = CAPTURE_BITS'($urandom);
            end else begin
                if ($urandom_range(9) == 0) begin
                    case ($urandom_range(4))
                        0: track_span = $urandom_range(1, 60);
                        1: track_span = $urandom_range(60, 120);
                        2: track_span = $urandom_range(120, 250);
                        3: track_span = $urandom_range(250, 3000);
                        default: track_span = $urandom_range(3000, 65535);
                    endcase
                end else begin
                    step = $urandom_range(track_span / 50 + 1);
                    if ($urandom_range(1) == 1 && track_span > step + 1)
                        track_span -= step;
                    else if (track_span + step <= 65535)
                        track_span += step;
                end
                b = a + CAPTURE_BITS'(track_span);
            end
            if ($urandom_range(199) == 0)
                wait_drained();
            send_pair(a, b);
        end
    endtask

    initial begin
        logic [CFG_DATA_W-1:0] vals[8];
        logic [CFG_DATA_W-1:0] lim;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED_PAIRS[i])
            send_pair(DIRECTED_PAIRS[i][31:16], DIRECTED_PAIRS[i][15:0]);
        wait_drained();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase != 0) begin
                wait_drained();
                repeat (SETTLE_CYCLES) @(posedge aclk);
                case (phase)
                    1: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 0, 0, 0};
                    2: vals = '{0, 0, 0, 0, 0, 0, 0, 0};
                    3: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                                16'hFFFF, 10000, 16'h3FFF, 16'hFFFF};
                    4: vals = '{30000, 8000, 40000, 12000, 10000, 5, 123, 9999};
                    5: vals = '{RST_BAND_ONE_LIMIT, RST_BAND_TWO_LIMIT,
                                RST_BAND_THREE_LIMIT, RST_BAND_FOUR_LIMIT,
                                CFG_DATA_W'(RST_BAND_ONE_BP), CFG_DATA_W'(RST_BAND_TWO_BP),
                                CFG_DATA_W'(RST_BAND_THREE_BP),
                                CFG_DATA_W'(RST_BAND_FOUR_BP)};
                    6: begin
                        lim = CFG_DATA_W'($urandom_range(1000, 8000));
                        vals[0] = lim;
                        lim += CFG_DATA_W'($urandom_range(8000));
                        vals[1] = lim;
                        lim += CFG_DATA_W'($urandom_range(15000));
                        vals[2] = lim;
                        lim += CFG_DATA_W'($urandom_range(20000));
                        vals[3] = lim;
                        for (int i = 4; i < 8; i++)
                            vals[i] = CFG_DATA_W'($urandom_range(2000));
                    end
                    default: begin
                        for (int i = 0; i < 8; i++)
                            vals[i] = CFG_DATA_W'($urandom);
                    end
                endcase
                load_settings(vals);
            end
            case (phase % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 48; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 48; end
                default: begin src_idle_pct = 28; sink_stall_pct = 28; end
            endcase
            send_random_pairs(ITEMS_PER_PHASE);
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0 && sb.expected_readings.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule
